/* sv/blls_pkg.sv */
`default_nettype none

package blls_pkg;

  localparam logic [15:0] DISCHARGE_PERIOD_RESET = 16'd500;
  localparam logic [7:0]  CHARGE_PERIOD_RESET    = 8'd250;

  localparam logic [2:0] LINE_ONE   = 3'b001;
  localparam logic [2:0] LINE_TWO   = 3'b010;
  localparam logic [2:0] LINE_THREE = 3'b100;

  localparam logic [2:0] LEVEL_MAX       = 3'd4;
  localparam logic [2:0] CHARGE_SLOT_MAX = 3'd5;

  typedef enum logic [1:0] {
    REG_DISCHARGE_PERIOD = 2'd0,
    REG_CHARGE_PERIOD    = 2'd1
  } reg_index_t;

  function automatic logic [2:0] slot_pattern(input logic [2:0] slot);
    logic [2:0] pattern;
    case (slot)
      3'd0:    pattern = LINE_ONE | LINE_TWO | LINE_THREE;
      3'd1:    pattern = LINE_ONE;
      3'd2:    pattern = LINE_TWO | LINE_THREE;
      3'd3:    pattern = LINE_TWO;
      3'd4:    pattern = LINE_ONE | LINE_THREE;
      3'd5:    pattern = LINE_ONE | LINE_TWO | LINE_THREE;
      default: pattern = 3'b000;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

/* sv/battery_level_led_scanner_top.sv */
// A tick's line levels pass the input register, then the line register.
// Throughput: one tick per cycle; the input register and the line register
// advance together whenever the output is empty or being taken.
// Reset: synchronous, active high; clears all counters and slots, turns all
// lines off and loads the blink periods with 500 and 250 ticks.
`default_nettype none

module battery_level_led_scanner_top
  import blls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        charging,
  input  wire logic [2:0]  level_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             line_one,
  output logic             line_two,
  output logic             line_three,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] discharge_blink_period;
  logic [7:0]  charge_blink_period;

  logic       s1_valid;
  logic       s1_charging;
  logic [2:0] s1_level;

  logic [1:0]  discharge_slot;
  logic [2:0]  charge_slot;
  logic [2:0]  latched_charge_level;
  logic [2:0]  shown_charge_level;
  logic        blink_phase;
  logic [15:0] discharge_blink_count;
  logic [7:0]  charge_blink_count;
  logic [2:0]  line_levels;

  logic [1:0]  discharge_slot_next;
  logic [2:0]  charge_slot_next;
  logic [2:0]  latched_charge_level_next;
  logic [2:0]  shown_charge_level_next;
  logic        blink_phase_next;
  logic [15:0] discharge_blink_count_next;
  logic [7:0]  charge_blink_count_next;
  logic [2:0]  line_levels_next;

  logic        advance;
  logic [2:0]  level_sat;
  logic [2:0]  want_level;
  logic [2:0]  shown_work;
  logic        phase_work;
  logic [2:0]  cur_slot;
  logic        slot_hit;
  logic [2:0]  discharge_index;
  logic [2:0]  discharge_lines;
  logic [15:0] discharge_count_inc;
  logic [7:0]  charge_count_inc;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  assign line_one   = line_levels[0];
  assign line_two   = line_levels[1];
  assign line_three = line_levels[2];

  assign level_sat = (s1_level > LEVEL_MAX) ? LEVEL_MAX : s1_level;

  always_comb begin
    discharge_slot_next        = discharge_slot;
    charge_slot_next           = charge_slot;
    latched_charge_level_next  = latched_charge_level;
    shown_charge_level_next    = shown_charge_level;
    blink_phase_next           = blink_phase;
    discharge_blink_count_next = discharge_blink_count;
    charge_blink_count_next    = charge_blink_count;
    line_levels_next           = line_levels;
    want_level          = (level_sat == 3'd0) ? 3'd1 : level_sat;
    shown_work          = shown_charge_level;
    phase_work          = blink_phase;
    cur_slot            = (charge_slot > CHARGE_SLOT_MAX) ? 3'd0 : charge_slot;
    slot_hit            = 1'b0;
    discharge_index     = {1'b0, discharge_slot} + 3'd1;
    discharge_lines     = line_levels;
    discharge_count_inc = discharge_blink_count + 16'd1;
    charge_count_inc    = charge_blink_count + 8'd1;

    if (s1_charging) begin
      discharge_slot_next        = 2'd0;
      discharge_blink_count_next = 16'd0;
      if (want_level != latched_charge_level) begin
        latched_charge_level_next = want_level;
        shown_work                = want_level;
        phase_work                = 1'b0;
      end
      slot_hit = (cur_slot == 3'd0) ? (shown_work == 3'd0) : (shown_work >= cur_slot);
      if (slot_hit) begin
        line_levels_next = slot_pattern(cur_slot);
      end
      charge_slot_next = (cur_slot >= CHARGE_SLOT_MAX) ? 3'd0 : cur_slot + 3'd1;
      if (charge_count_inc >= charge_blink_period) begin
        charge_blink_count_next = 8'd0;
        blink_phase_next        = !phase_work;
        shown_charge_level_next = phase_work ? shown_work + 3'd1 : shown_work - 3'd1;
      end else begin
        charge_blink_count_next = charge_count_inc;
        blink_phase_next        = phase_work;
        shown_charge_level_next = shown_work;
      end
    end else begin
      charge_slot_next          = 3'd0;
      latched_charge_level_next = 3'd0;
      shown_charge_level_next   = 3'd0;
      blink_phase_next          = 1'b0;
      charge_blink_count_next   = 8'd0;
      if (level_sat >= discharge_index) begin
        discharge_lines = slot_pattern(discharge_index);
      end
      discharge_slot_next = discharge_slot + 2'd1;
      if (level_sat == 3'd0) begin
        if (discharge_count_inc >= discharge_blink_period) begin
          discharge_blink_count_next = 16'd0;
          discharge_lines            = discharge_lines ^ LINE_ONE;
        end else begin
          discharge_blink_count_next = discharge_count_inc;
        end
        discharge_lines = discharge_lines & LINE_ONE;
      end
      line_levels_next = discharge_lines;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discharge_blink_period <= DISCHARGE_PERIOD_RESET;
      charge_blink_period    <= CHARGE_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DISCHARGE_PERIOD: discharge_blink_period <= cfg_data;
        REG_CHARGE_PERIOD:    charge_blink_period    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_charging <= charging;
      s1_level    <= level_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discharge_slot        <= 2'd0;
      charge_slot           <= 3'd0;
      latched_charge_level  <= 3'd0;
      shown_charge_level    <= 3'd0;
      blink_phase           <= 1'b0;
      discharge_blink_count <= 16'd0;
      charge_blink_count    <= 8'd0;
      line_levels           <= 3'd0;
    end else if (advance) begin
      discharge_slot        <= discharge_slot_next;
      charge_slot           <= charge_slot_next;
      latched_charge_level  <= latched_charge_level_next;
      shown_charge_level    <= shown_charge_level_next;
      blink_phase           <= blink_phase_next;
      discharge_blink_count <= discharge_blink_count_next;
      charge_blink_count    <= charge_blink_count_next;
      line_levels           <= line_levels_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    charge_slot <= CHARGE_SLOT_MAX)
    else $error("charge slot out of range");

  assert property (@(posedge clk) disable iff (rst)
    charge_slot != 3'd0 |-> latched_charge_level != 3'd0)
    else $error("charge slot running without a latched level");

  assert property (@(posedge clk) disable iff (rst)
    advance && !s1_charging |=> charge_slot == 3'd0 && latched_charge_level == 3'd0
      && shown_charge_level == 3'd0 && !blink_phase && charge_blink_count == 8'd0)
    else $error("discharge tick left charge state behind");

  assert property (@(posedge clk) disable iff (rst)
    advance && !s1_charging && s1_level == 3'd0 |=> out_valid && !line_two && !line_three)
    else $error("lowest level must drive only line one");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_level) && $stable(s1_charging))
    else $error("input register lost a stalled tick");

endmodule

`default_nettype wire
